### sv/pise_pkg.sv
// ----------------------------------------------------------------
// pise_pkg
// Shared types and constants of the indexed PNG encoder.
// ----------------------------------------------------------------
package pise_pkg;

	localparam logic [31:0] CRC_POLY    = 32'hedb88320;
	localparam logic [31:0] CRC_SEED    = 32'hffffffff;
	localparam logic [16:0] ADLER_MOD   = 17'd65521;
	localparam logic [15:0] BLOCK_LIMIT = 16'hffff;
	localparam logic [14:0] DIM_MAX     = 15'd16384;
	localparam logic [8:0]  PAL_MAX     = 9'd256;
	localparam logic [7:0]  ZLIB_CMF    = 8'h78;
	localparam logic [7:0]  ZLIB_FLG    = 8'h01;
	localparam logic [31:0] TAG_IHDR    = 32'h49484452;
	localparam logic [31:0] TAG_PLTE    = 32'h504c5445;
	localparam logic [31:0] TAG_IDAT    = 32'h49444154;
	localparam logic [31:0] TAG_IEND    = 32'h49454e44;
	localparam logic [7:0]  SIG_BYTES [8] = '{8'h89, 8'h50, 8'h4e, 8'h47,
		8'h0d, 8'h0a, 8'h1a, 8'h0a};

	localparam int Q_DEPTH = 4;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_PAL    = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		CMD_ERR = 3'b001,
		CMD_PAL = 3'b010,
		CMD_PIX = 3'b100
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        first;
		logic        last;
		logic        row_start;
		logic [23:0] data;
	} cmd_t;

	typedef struct packed {
		logic [14:0] width;
		logic [14:0] height;
		logic [8:0]  pal_count;
	} cfg_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] x;
		x = c ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
		end
		return x;
	endfunction

	function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] i);
		logic [7:0] r;
		case (i)
			2'd0: r = w[31:24];
			2'd1: r = w[23:16];
			2'd2: r = w[15:8];
			default: r = w[7:0];
		endcase
		return r;
	endfunction

endpackage

### sv/png_indexed_stored_encoder_top.sv
// ----------------------------------------------------------------
// png_indexed_stored_encoder_top
// Streams a palette and 8-bit indices into the bytes of a PNG file.
// ----------------------------------------------------------------
// Usage: program image_width, image_height and palette_count over the
// register port, then send palette_count palette words (operation 0)
// followed by width*height pixel words (operation 1) in row order.
// Each input word expands into one or more output words of one file
// byte each; run_last marks the last output word of an input word and
// file_last the final byte of the file. A word out of order gives a
// single output word with order_error set and changes nothing.
// Input words land in a four-entry command queue; while out_ready is
// high a sequencer emits one output word per cycle into the output
// register, taking each word from the queue into its command register
// first. Steady pixel input within a row runs at one word per cycle
// while out_ready is high; header, filter, block header and trailer
// bytes hold the sequencer, so the queue can fill and in_ready drop.
// When out_ready is low the output register holds and the queue takes
// up to four more words. Reset returns the block to the start of a file
// with default register values; only a reset starts a new file.
// ----------------------------------------------------------------
module png_indexed_stored_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  color_red,
	input  logic [7:0]  color_green,
	input  logic [7:0]  color_blue,
	input  logic [7:0]  pixel_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        order_error,
	output logic        run_last,
	output logic        file_last
);
	import pise_pkg::*;

	cfg_t cfg;
	cmd_t push_cmd;
	cmd_t head_cmd;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_not_empty;

	assign pready = 1'b1;

	pise_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.color_red   (color_red),
		.color_green (color_green),
		.color_blue  (color_blue),
		.pixel_index (pixel_index),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (push_cmd),
		.cfg         (cfg)
	);

	pise_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.pop       (q_pop),
		.head_cmd  (head_cmd),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	pise_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.head_cmd    (head_cmd),
		.q_not_empty (q_not_empty),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.order_error (order_error),
		.run_last    (run_last),
		.file_last   (file_last)
	);

endmodule

### sv/pise_front.sv
// ----------------------------------------------------------------
// pise_front
// Register port and item classifier: tracks file progress and turns
// each accepted item into a command for the byte sequencer.
// ----------------------------------------------------------------
module pise_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [7:0]         color_red,
	input  logic [7:0]         color_green,
	input  logic [7:0]         color_blue,
	input  logic [7:0]         pixel_index,
	input  logic               q_full,
	output logic               q_push,
	output pise_pkg::cmd_t     q_cmd,
	output pise_pkg::cfg_t     cfg
);
	import pise_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_PALETTE = 4'b0010,
		ST_PIXELS  = 4'b0100,
		ST_DONE    = 4'b1000
	} st_t;

	st_t         stage_q;
	logic [8:0]  seen_q;
	logic [13:0] col_q;
	logic [13:0] row_q;
	cfg_t        cfg_q;

	logic        wr_en;
	logic [14:0] dim_val;
	logic [14:0] dim_sat;
	logic [8:0]  pal_val;
	logic [8:0]  pal_sat;
	logic [8:0]  seen_next;
	logic        col_last;
	logic        row_last;
	logic        is_pal;
	logic        is_pix;

	assign cfg = cfg_q;
	assign wr_en = psel && penable && pwrite
		&& (stage_q != ST_PALETTE) && (stage_q != ST_PIXELS);

	assign dim_val = pwdata[14:0];
	assign dim_sat = (dim_val == 15'd0) ? 15'd1 : ((dim_val > DIM_MAX) ? DIM_MAX : dim_val);
	assign pal_val = pwdata[8:0];
	assign pal_sat = (pal_val == 9'd0) ? 9'd1 : ((pal_val > PAL_MAX) ? PAL_MAX : pal_val);

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_WIDTH:  prdata = {17'h0, cfg_q.width};
			REG_HEIGHT: prdata = {17'h0, cfg_q.height};
			REG_PAL:    prdata = {23'h0, cfg_q.pal_count};
			default:    prdata = 32'h0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width     <= 15'd1;
			cfg_q.height    <= 15'd1;
			cfg_q.pal_count <= PAL_MAX;
		end else if (wr_en) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_WIDTH:  cfg_q.width     <= dim_sat;
				REG_HEIGHT: cfg_q.height    <= dim_sat;
				REG_PAL:    cfg_q.pal_count <= pal_sat;
				default:    ;
			endcase
		end
	end

	assign in_ready  = !q_full;
	assign q_push    = in_valid && !q_full;
	assign is_pal    = !operation && (stage_q == ST_IDLE || stage_q == ST_PALETTE);
	assign is_pix    = operation && (stage_q == ST_PIXELS);
	assign seen_next = ((stage_q == ST_IDLE) ? 9'd0 : seen_q) + 9'd1;
	assign col_last  = ({1'b0, col_q} + 15'd1) >= cfg_q.width;
	assign row_last  = ({1'b0, row_q} + 15'd1) >= cfg_q.height;

	always_comb begin
		q_cmd = '0;
		if (is_pal) begin
			q_cmd.kind  = CMD_PAL;
			q_cmd.first = (stage_q == ST_IDLE);
			q_cmd.last  = (seen_next >= cfg_q.pal_count);
			q_cmd.data  = {color_red, color_green, color_blue};
		end else if (is_pix) begin
			q_cmd.kind      = CMD_PIX;
			q_cmd.first     = (col_q == 14'd0) && (row_q == 14'd0);
			q_cmd.row_start = (col_q == 14'd0);
			q_cmd.last      = col_last && row_last;
			q_cmd.data      = {16'h0, pixel_index};
		end else begin
			q_cmd.kind = CMD_ERR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_IDLE;
			seen_q  <= 9'd0;
			col_q   <= 14'd0;
			row_q   <= 14'd0;
		end else if (q_push) begin
			if (is_pal) begin
				seen_q <= seen_next;
				if (q_cmd.last) begin
					stage_q <= ST_PIXELS;
					col_q   <= 14'd0;
					row_q   <= 14'd0;
				end else begin
					stage_q <= ST_PALETTE;
				end
			end else if (is_pix) begin
				if (col_last) begin
					col_q <= 14'd0;
					row_q <= row_q + 14'd1;
				end else begin
					col_q <= col_q + 14'd1;
				end
				if (q_cmd.last) begin
					stage_q <= ST_DONE;
				end
			end
		end
	end

endmodule

### sv/pise_queue.sv
// ----------------------------------------------------------------
// pise_queue
// Short command queue between the classifier and the sequencer.
// ----------------------------------------------------------------
module pise_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pise_pkg::cmd_t push_cmd,
	input  logic           pop,
	output pise_pkg::cmd_t head_cmd,
	output logic           not_empty,
	output logic           full
);
	import pise_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);

	cmd_t            mem_q [Q_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign head_cmd  = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == (PW+1)'(Q_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/pise_back.sv
// ----------------------------------------------------------------
// pise_back
// Byte sequencer: expands commands into file bytes, keeps the chunk
// CRC, the Adler-32 sums and the stored block counters.
// ----------------------------------------------------------------
module pise_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pise_pkg::cfg_t cfg,
	input  pise_pkg::cmd_t head_cmd,
	input  logic           q_not_empty,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           byte_valid,
	output logic           order_error,
	output logic           run_last,
	output logic           file_last
);
	import pise_pkg::*;

	typedef enum logic [7:0] {
		P_HDR   = 8'b00000001,
		P_COLOR = 8'b00000010,
		P_PCRC  = 8'b00000100,
		P_IDATH = 8'b00001000,
		P_FILT  = 8'b00010000,
		P_PIX   = 8'b00100000,
		P_TRAIL = 8'b01000000,
		P_ERR   = 8'b10000000
	} phase_t;

	// idat length, recomputed from the registers in three steps
	logic [28:0] total_s1;
	logic [13:0] blocks_s2;
	logic [28:0] total_s2;
	logic [31:0] idat_len_s3;
	logic [29:0] tsum;
	logic [13:0] q0;
	logic [16:0] rem;

	assign tsum = {1'b0, total_s1} + 30'd65534;
	assign q0   = tsum[29:16];
	assign rem  = {1'b0, tsum[15:0]} + {3'b0, q0};

	always_ff @(posedge clk) begin
		total_s1    <= ({14'h0, cfg.width} + 29'd1) * {14'h0, cfg.height};
		total_s2    <= total_s1;
		blocks_s2   <= q0 + ((rem >= {1'b0, BLOCK_LIMIT}) ? 14'd1 : 14'd0);
		idat_len_s3 <= 32'd6 + {3'b0, total_s2} + {16'h0, blocks_s2, 2'b00}
			+ {18'h0, blocks_s2};
	end

	cmd_t        cur_q;
	phase_t      phase_q;
	logic [5:0]  idx_q;
	logic        busy_q;
	logic [2:0]  bh_q;
	logic [31:0] crc_q;
	logic [15:0] adl_lo_q;
	logic [15:0] adl_hi_q;
	logic [15:0] blk_left_q;
	logic [28:0] raw_left_q;

	logic        slot_free;
	logic        emit;
	logic [7:0]  b;
	logic        crc_inc;
	logic        crc_restart;
	logic        raw_byte;
	logic        bhdr_byte;
	logic        ph_end;
	logic        cmd_done;
	logic        file_end;
	logic        err_item;
	logic        pix_init;
	phase_t      next_ph;
	phase_t      init_ph;
	logic [1:0]  sel_m1;
	logic [15:0] blk_n;
	logic        blk_final;
	logic [10:0] pal_bytes;
	logic [31:0] crc_base;
	logic [16:0] lo_sum;
	logic [15:0] lo_new;
	logic [16:0] hi_sum;
	logic [15:0] hi_new;

	assign slot_free = !out_valid || out_ready;
	assign emit      = busy_q && slot_free;
	assign q_pop     = q_not_empty && (!busy_q || (emit && cmd_done));
	assign sel_m1    = idx_q[1:0] - 2'd1;
	assign pal_bytes = {1'b0, cfg.pal_count, 1'b0} + {2'b0, cfg.pal_count};
	assign blk_n     = (raw_left_q > {13'h0, BLOCK_LIMIT}) ? BLOCK_LIMIT : raw_left_q[15:0];
	assign blk_final = (raw_left_q <= {13'h0, BLOCK_LIMIT});

	always_comb begin
		unique case (head_cmd.kind)
			CMD_PAL: init_ph = head_cmd.first ? P_HDR : P_COLOR;
			CMD_PIX: init_ph = head_cmd.first ? P_IDATH
				: (head_cmd.row_start ? P_FILT : P_PIX);
			default: init_ph = P_ERR;
		endcase
	end

	always_comb begin
		b           = 8'h00;
		crc_inc     = 1'b0;
		crc_restart = 1'b0;
		raw_byte    = 1'b0;
		bhdr_byte   = 1'b0;
		ph_end      = 1'b0;
		next_ph     = phase_q;
		cmd_done    = 1'b0;
		file_end    = 1'b0;
		err_item    = 1'b0;
		pix_init    = 1'b0;
		unique case (phase_q)
			P_HDR: begin
				case (idx_q) inside
					[6'd0:6'd7]:   b = SIG_BYTES[idx_q[2:0]];
					[6'd8:6'd11]:  b = be_byte(32'd13, idx_q[1:0]);
					[6'd12:6'd15]: b = be_byte(TAG_IHDR, idx_q[1:0]);
					[6'd16:6'd19]: b = be_byte({17'h0, cfg.width}, idx_q[1:0]);
					[6'd20:6'd23]: b = be_byte({17'h0, cfg.height}, idx_q[1:0]);
					6'd24:         b = 8'd8;
					6'd25:         b = 8'd3;
					[6'd26:6'd28]: b = 8'd0;
					[6'd29:6'd32]: b = be_byte(~crc_q, sel_m1);
					[6'd33:6'd36]: b = be_byte({21'h0, pal_bytes}, sel_m1);
					default:       b = be_byte(TAG_PLTE, sel_m1);
				endcase
				crc_inc     = ((idx_q >= 6'd12) && (idx_q <= 6'd28)) || (idx_q >= 6'd37);
				crc_restart = (idx_q == 6'd12) || (idx_q == 6'd37);
				ph_end      = (idx_q == 6'd40);
				next_ph     = P_COLOR;
			end
			P_COLOR: begin
				case (idx_q[1:0])
					2'd0:    b = cur_q.data[23:16];
					2'd1:    b = cur_q.data[15:8];
					default: b = cur_q.data[7:0];
				endcase
				crc_inc  = 1'b1;
				ph_end   = (idx_q == 6'd2);
				next_ph  = P_PCRC;
				cmd_done = ph_end && !cur_q.last;
			end
			P_PCRC: begin
				b        = be_byte(~crc_q, idx_q[1:0]);
				ph_end   = (idx_q == 6'd3);
				cmd_done = ph_end;
				pix_init = ph_end;
			end
			P_IDATH: begin
				case (idx_q) inside
					[6'd0:6'd3]: b = be_byte(idat_len_s3, idx_q[1:0]);
					[6'd4:6'd7]: b = be_byte(TAG_IDAT, idx_q[1:0]);
					6'd8:        b = ZLIB_CMF;
					default:     b = ZLIB_FLG;
				endcase
				crc_inc     = (idx_q >= 6'd4);
				crc_restart = (idx_q == 6'd4);
				ph_end      = (idx_q == 6'd9);
				next_ph     = P_FILT;
			end
			P_FILT, P_PIX: begin
				crc_inc = 1'b1;
				if (blk_left_q == 16'd0) begin
					// stored block header before the next raw word
					bhdr_byte = 1'b1;
					case (bh_q)
						3'd0:    b = {7'h0, blk_final};
						3'd1:    b = blk_n[7:0];
						3'd2:    b = blk_n[15:8];
						3'd3:    b = ~blk_n[7:0];
						default: b = ~blk_n[15:8];
					endcase
				end else begin
					raw_byte = 1'b1;
					b        = (phase_q == P_FILT) ? 8'h00 : cur_q.data[7:0];
					ph_end   = 1'b1;
					next_ph  = (phase_q == P_FILT) ? P_PIX : P_TRAIL;
					cmd_done = (phase_q == P_PIX) && !cur_q.last;
				end
			end
			P_TRAIL: begin
				case (idx_q) inside
					[6'd0:6'd3]:   b = be_byte({adl_hi_q, adl_lo_q}, idx_q[1:0]);
					[6'd8:6'd11]:  b = 8'h00;
					[6'd12:6'd15]: b = be_byte(TAG_IEND, idx_q[1:0]);
					default:       b = be_byte(~crc_q, idx_q[1:0]);
				endcase
				crc_inc     = (idx_q <= 6'd3) || ((idx_q >= 6'd12) && (idx_q <= 6'd15));
				crc_restart = (idx_q == 6'd12);
				ph_end      = (idx_q == 6'd19);
				cmd_done    = ph_end;
				file_end    = ph_end;
			end
			default: begin
				err_item = 1'b1;
				ph_end   = 1'b1;
				cmd_done = 1'b1;
			end
		endcase
	end

	assign crc_base = crc_restart ? CRC_SEED : crc_q;
	assign lo_sum   = {1'b0, adl_lo_q} + {9'h0, b};
	assign lo_new   = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
	assign hi_sum   = {1'b0, adl_hi_q} + {1'b0, lo_new};
	assign hi_new   = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			cur_q      <= '0;
			phase_q    <= P_ERR;
			idx_q      <= 6'd0;
			bh_q       <= 3'd0;
			crc_q      <= CRC_SEED;
			adl_lo_q   <= 16'd1;
			adl_hi_q   <= 16'd0;
			blk_left_q <= 16'd0;
			raw_left_q <= 29'd0;
		end else begin
			if (emit) begin
				if (crc_inc) begin
					crc_q <= crc_byte(crc_base, b);
				end
				if (bhdr_byte) begin
					if (bh_q == 3'd4) begin
						bh_q       <= 3'd0;
						blk_left_q <= blk_n;
					end else begin
						bh_q <= bh_q + 3'd1;
					end
				end
				if (raw_byte) begin
					adl_lo_q   <= lo_new;
					adl_hi_q   <= hi_new;
					blk_left_q <= blk_left_q - 16'd1;
					raw_left_q <= raw_left_q - 29'd1;
				end
				if (pix_init) begin
					raw_left_q <= total_s2;
					blk_left_q <= 16'd0;
					bh_q       <= 3'd0;
					adl_lo_q   <= 16'd1;
					adl_hi_q   <= 16'd0;
				end
			end
			if (q_pop) begin
				busy_q  <= 1'b1;
				cur_q   <= head_cmd;
				phase_q <= init_ph;
				idx_q   <= 6'd0;
			end else if (emit) begin
				if (ph_end) begin
					idx_q   <= 6'd0;
					phase_q <= next_ph;
				end else if (!bhdr_byte) begin
					idx_q <= idx_q + 6'd1;
				end
				if (cmd_done) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (slot_free) begin
			out_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte    <= err_item ? 8'h00 : b;
			byte_valid  <= !err_item;
			order_error <= err_item;
			run_last    <= cmd_done;
			file_last   <= file_end;
		end
	end

endmodule

### sv/pise_checker.sv
// ----------------------------------------------------------------
// pise_checker
// Port-level checks on the output words of the encoder.
// ----------------------------------------------------------------
module pise_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       order_error,
	input logic       run_last,
	input logic       file_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("output word changed while stalled");

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && order_error |-> run_last && !byte_valid && !file_last
			&& (out_byte == 8'h00))
		else $error("bad order error word");

	a_file_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && file_last |-> run_last && byte_valid)
		else $error("file end not closing its run");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_valid != order_error)
		else $error("word is neither a byte nor an error");

endmodule

bind png_indexed_stored_encoder_top pise_checker u_pise_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_byte    (out_byte),
	.byte_valid  (byte_valid),
	.order_error (order_error),
	.run_last    (run_last),
	.file_last   (file_last)
);

### tb/png_stream_checker.sv
// ----------------------------------------------------------------
// png_stream_checker
// Watches the register port and both word channels of the indexed
// PNG encoder, predicts every file byte and compares the output.
// ----------------------------------------------------------------
module png_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  color_red,
	input  logic [7:0]  color_green,
	input  logic [7:0]  color_blue,
	input  logic [7:0]  pixel_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic        byte_valid,
	input  logic        order_error,
	input  logic        run_last,
	input  logic        file_last,
	output int          fail_count,
	output int          bytes_pending
);
	import pise_pkg::*;

	typedef enum logic [1:0] {
		FILE_IDLE,
		FILE_PALETTE,
		FILE_PIXELS,
		FILE_DONE
	} file_stage_t;

	typedef struct {
		logic [7:0] data;
		logic       valid_byte;
		logic       err;
		logic       word_end;
		logic       file_end;
	} file_byte_t;

	file_byte_t  expected_bytes[$];
	file_stage_t stage;
	logic [14:0] cfg_width, cfg_height;
	logic [8:0]  cfg_pal;
	logic [8:0]  pal_seen;
	logic [14:0] col, row;
	logic [63:0] raw_left;
	logic [31:0] blk_left, adl_lo, adl_hi, crc;

	assign bytes_pending = expected_bytes.size();

	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] x;
		x = c ^ {24'h0, b};
		for (int k = 0; k < 8; k++)
			x = x[0] ? (32'hedb88320 ^ (x >> 1)) : (x >> 1);
		return x;
	endfunction

	function automatic logic [14:0] sat_dim(input logic [31:0] v, input logic [14:0] hi);
		logic [14:0] t;
		t = v[14:0];
		if (t == 0) return 15'd1;
		if (t > hi) return hi;
		return t;
	endfunction

	task automatic emit(input logic [7:0] b, input bit in_crc);
		file_byte_t e;
		if (in_crc) crc = crc_step(crc, b);
		e.data = b;
		e.valid_byte = 1'b1;
		e.err = 1'b0;
		e.word_end = 1'b0;
		e.file_end = 1'b0;
		expected_bytes.push_back(e);
	endtask

	task automatic emit32(input logic [31:0] v, input bit in_crc);
		emit(v[31:24], in_crc);
		emit(v[23:16], in_crc);
		emit(v[15:8], in_crc);
		emit(v[7:0], in_crc);
	endtask

	task automatic emit_tag(input logic [31:0] tag);
		crc = 32'hffffffff;
		emit32(tag, 1'b1);
	endtask

	// stored block header opens whenever the current block is used up
	task automatic emit_raw(input logic [7:0] b);
		logic [31:0] n;
		logic [15:0] inv;
		if (blk_left == 0) begin
			n = (raw_left > 64'd65535) ? 32'd65535 : raw_left[31:0];
			inv = ~n[15:0];
			emit((64'(n) == raw_left) ? 8'd1 : 8'd0, 1'b1);
			emit(n[7:0], 1'b1);
			emit(n[15:8], 1'b1);
			emit(inv[7:0], 1'b1);
			emit(inv[15:8], 1'b1);
			blk_left = n;
		end
		emit(b, 1'b1);
		adl_lo = adl_lo + b;
		if (adl_lo >= 65521) adl_lo = adl_lo - 65521;
		adl_hi = adl_hi + adl_lo;
		if (adl_hi >= 65521) adl_hi = adl_hi - 65521;
		if (blk_left != 0) blk_left--;
		if (raw_left != 0) raw_left--;
	endtask

	task automatic predict_word();
		int          first_idx;
		logic [63:0] total, blocks;
		file_byte_t  e;
		first_idx = expected_bytes.size();
		if (!operation && (stage == FILE_IDLE || stage == FILE_PALETTE)) begin
			if (stage == FILE_IDLE) begin
				for (int i = 0; i < 8; i++) emit(SIG_BYTES[i], 1'b0);
				emit32(32'd13, 1'b0);
				emit_tag(TAG_IHDR);
				emit32({17'd0, cfg_width}, 1'b1);
				emit32({17'd0, cfg_height}, 1'b1);
				emit(8'd8, 1'b1);
				emit(8'd3, 1'b1);
				emit(8'd0, 1'b1);
				emit(8'd0, 1'b1);
				emit(8'd0, 1'b1);
				emit32(~crc, 1'b0);
				emit32({23'd0, cfg_pal} * 3, 1'b0);
				emit_tag(TAG_PLTE);
				pal_seen = 0;
				stage = FILE_PALETTE;
			end
			emit(color_red, 1'b1);
			emit(color_green, 1'b1);
			emit(color_blue, 1'b1);
			pal_seen++;
			if (pal_seen >= cfg_pal) begin
				emit32(~crc, 1'b0);
				stage = FILE_PIXELS;
				raw_left = (64'(cfg_width) + 1) * cfg_height;
				blk_left = 0;
				col = 0;
				row = 0;
				adl_lo = 1;
				adl_hi = 0;
			end
		end else if (operation && stage == FILE_PIXELS) begin
			if (col == 0 && row == 0) begin
				total = (64'(cfg_width) + 1) * cfg_height;
				blocks = (total + 65534) / 65535;
				emit32(32'(2 + total + 5 * blocks + 4), 1'b0);
				emit_tag(TAG_IDAT);
				emit(ZLIB_CMF, 1'b1);
				emit(ZLIB_FLG, 1'b1);
			end
			if (col == 0) emit_raw(8'd0);
			emit_raw(pixel_index);
			col++;
			if (col >= cfg_width) begin
				col = 0;
				row++;
			end
			if (raw_left == 0) begin
				emit(adl_hi[15:8], 1'b1);
				emit(adl_hi[7:0], 1'b1);
				emit(adl_lo[15:8], 1'b1);
				emit(adl_lo[7:0], 1'b1);
				emit32(~crc, 1'b0);
				emit32(32'd0, 1'b0);
				emit_tag(TAG_IEND);
				emit32(~crc, 1'b0);
				expected_bytes[expected_bytes.size() - 1].file_end = 1'b1;
				stage = FILE_DONE;
			end
		end else begin
			e.data = 8'd0;
			e.valid_byte = 1'b0;
			e.err = 1'b1;
			e.word_end = 1'b0;
			e.file_end = 1'b0;
			expected_bytes.push_back(e);
		end
		// never more than 48 bytes per word
		while (expected_bytes.size() - first_idx > 48) void'(expected_bytes.pop_back());
		expected_bytes[expected_bytes.size() - 1].word_end = 1'b1;
	endtask

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("png_stream_checker: %s got %0h want %0h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		file_byte_t e;
		if (!arst_n) begin
			expected_bytes.delete();
			fail_count = 0;
			stage = FILE_IDLE;
			cfg_width = 15'd1;
			cfg_height = 15'd1;
			cfg_pal = 9'd256;
			pal_seen = 0;
			col = 0;
			row = 0;
			raw_left = 0;
			blk_left = 0;
			adl_lo = 1;
			adl_hi = 0;
			crc = 32'hffffffff;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					report("unexpected word", out_byte, 8'd0);
				end else begin
					e = expected_bytes.pop_front();
					if (out_byte !== e.data) report("out_byte", out_byte, e.data);
					if (byte_valid !== e.valid_byte)
						report("byte_valid", {7'h0, byte_valid}, {7'h0, e.valid_byte});
					if (order_error !== e.err)
						report("order_error", {7'h0, order_error}, {7'h0, e.err});
					if (run_last !== e.word_end)
						report("run_last", {7'h0, run_last}, {7'h0, e.word_end});
					if (file_last !== e.file_end)
						report("file_last", {7'h0, file_last}, {7'h0, e.file_end});
				end
			end
			if (psel && penable && pwrite && pready
					&& stage != FILE_PALETTE && stage != FILE_PIXELS) begin
				case (paddr[3:2])
					REG_WIDTH:  cfg_width = sat_dim(pwdata, DIM_MAX);
					REG_HEIGHT: cfg_height = sat_dim(pwdata, DIM_MAX);
					REG_PAL: begin
						if (pwdata[8:0] == 0) cfg_pal = 9'd1;
						else if (pwdata[8:0] > PAL_MAX) cfg_pal = PAL_MAX;
						else cfg_pal = pwdata[8:0];
					end
					default: ;
				endcase
			end
			if (in_valid && in_ready) predict_word();
		end
	end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------
// testbench
// Drives one whole PNG file through the indexed encoder: register
// setup with saturating values, palette, pixels with stray words,
// then words after the end. Random gaps and stalls on both sides.
// ----------------------------------------------------------------
module testbench;
	import pise_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = 1'b0;
	logic [7:0]  color_red = '0, color_green = '0, color_blue = '0, pixel_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_valid, order_error, run_last, file_last;
	int          fail_count, bytes_pending;
	bit          hold_off_req = 1'b0;
	int          idle_cycles = 0;
	int          width, height;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	png_indexed_stored_encoder_top DUT (.*);

	png_stream_checker checker_i (.*);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_word(input logic op, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] pix);
		int gap;
		in_valid <= 1'b1;
		operation <= op;
		color_red <= r;
		color_green <= g;
		color_blue <= b;
		pixel_index <= pix;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_word(input logic op);
		send_word(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (bytes_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int r;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off_req = 1'b0;
			end
			r = $urandom_range(0, 99);
			if (r < 60) out_ready <= 1'b1;
			else if (r < 95) out_ready <= 1'b0;
			else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(5, 30)) @(posedge clk);
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000) begin
			$display("png_indexed_stored_encoder_top: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// saturating values first, then the real setting
		reg_write(REG_WIDTH, 32'h0);
		reg_write(REG_WIDTH, 32'h7fff);
		reg_write(REG_HEIGHT, 32'h7fff);
		reg_write(REG_PAL, 32'h0);
		reg_write(REG_PAL, 32'h1ff);
		width = $urandom_range(1, 12);
		height = (110 + width - 1) / width;
		reg_write(REG_WIDTH, 32'(width));
		reg_write(REG_HEIGHT, 32'(height));
		reg_write(REG_PAL, 32'd4);

		send_random_word(1'b1);
		send_word(1'b0, 8'h00, 8'h00, 8'h00, 8'hff);
		send_word(1'b0, 8'hff, 8'hff, 8'hff, 8'h00);
		send_random_word(1'b0);
		send_random_word(1'b0);
		send_random_word(1'b0);
		drain();

		send_word(1'b1, 8'hff, 8'hff, 8'hff, 8'h00);
		send_word(1'b1, 8'h00, 8'h00, 8'h00, 8'hff);
		for (int i = 2; i < width * height; i++) begin
			if (i == 30) hold_off_req = 1'b1;
			if ($urandom_range(0, 9) == 0) send_random_word(1'b0);
			send_random_word(1'b1);
		end
		repeat (10) send_random_word(1'($urandom_range(0, 1)));
		drain();

		// file is done: writes land again, extremes included
		reg_write(REG_WIDTH, 32'h7fff);
		reg_write(REG_HEIGHT, 32'h1);
		reg_write(REG_PAL, 32'h1ff);
		repeat (6) send_random_word(1'($urandom_range(0, 1)));
		drain();
		repeat (30) @(posedge clk);

		if (fail_count == 0) $display("png_indexed_stored_encoder_top: match");
		else $display("png_indexed_stored_encoder_top: mismatch");
		$finish;
	end

endmodule
